>>> design/rigid_body_3dof_euler_step_defines.svh
// ----------------------------------------------------------------------------
// rigid body euler step - assertion macros
// shared helpers for the port checker
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_3DOF_EULER_STEP_DEFINES_SVH
`define RIGID_BODY_3DOF_EULER_STEP_DEFINES_SVH

// property checked only out of reset
`define RBE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define RBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// constants, codes, step schedule and helpers of the rigid body euler step
// ----------------------------------------------------------------------------
package rbe_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int CORD_CNT_W    = $clog2(CORDIC_STAGES + 1);
    localparam int ATAN_IDX_W    = 5;
    localparam int CORD_W        = 34;
    localparam int CORD_Z_W      = 33;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [47:0] RAD_TO_BAM = 48'd44798133900177;

    localparam logic [31:0] ATAN_BAM [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_TIME  = 3'd0,
        REG_INV_SURGE  = 3'd1,
        REG_INV_SWAY   = 3'd2,
        REG_INV_CROSS  = 3'd3,
        REG_INV_YAW    = 3'd4
    } t_reg_idx;

    localparam int MUL_A_W  = 64;
    localparam int MUL_B_W  = 48;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int DIGIT_W  = 16;
    localparam int PP_W     = MUL_A_W + DIGIT_W + 1;
    localparam logic [1:0] LAST_DIGIT = 2'd2;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

    typedef enum logic [3:0] {
        A_FU, A_FV, A_MZ, A_ACCU, A_ACCV, A_ACCR,
        A_COS, A_SIN, A_RU, A_RV, A_VELR, A_PROD
    } t_asel;

    typedef enum logic [2:0] {
        B_INV_SURGE, B_INV_SWAY, B_INV_CROSS, B_INV_YAW,
        B_DT, B_VELU, B_VELV, B_RAD2BAM
    } t_bsel;

    typedef enum logic [3:0] {
        WB_NONE, WB_ACCU, WB_ACCV, WB_ACCR, WB_VELU, WB_VELV, WB_VELR,
        WB_RU, WB_RV, WB_PROD, WB_POSN, WB_POSE, WB_HEAD
    } t_wb;

    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        logic  accum;
        logic  sub;
        logic  need_cordic;
        t_wb   wb;
    } t_step;

    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [1:0] digit;
        t_asel      asel;
        t_bsel      bsel;
        logic       accum;
        logic       sub;
        t_wb        wb;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic cordic_done;
    } t_status;

    // product schedule; a result is written back during the next step's first digit, the last in S_FIN
    function automatic t_step step_rom(input logic [STEP_W-1:0] idx);
        t_step s;
        case (idx)
            4'd0:  s = '{A_FU,   B_INV_SURGE, 1'b0, 1'b0, 1'b0, WB_ACCU};
            4'd1:  s = '{A_FV,   B_INV_SWAY,  1'b0, 1'b0, 1'b0, WB_NONE};
            4'd2:  s = '{A_MZ,   B_INV_CROSS, 1'b1, 1'b0, 1'b0, WB_ACCV};
            4'd3:  s = '{A_FV,   B_INV_CROSS, 1'b0, 1'b0, 1'b0, WB_NONE};
            4'd4:  s = '{A_MZ,   B_INV_YAW,   1'b1, 1'b0, 1'b0, WB_ACCR};
            4'd5:  s = '{A_ACCU, B_DT,        1'b0, 1'b0, 1'b0, WB_VELU};
            4'd6:  s = '{A_ACCV, B_DT,        1'b0, 1'b0, 1'b0, WB_VELV};
            4'd7:  s = '{A_ACCR, B_DT,        1'b0, 1'b0, 1'b0, WB_VELR};
            4'd8:  s = '{A_COS,  B_VELU,      1'b0, 1'b0, 1'b1, WB_NONE};
            4'd9:  s = '{A_SIN,  B_VELV,      1'b1, 1'b1, 1'b0, WB_RU};
            4'd10: s = '{A_SIN,  B_VELU,      1'b0, 1'b0, 1'b0, WB_NONE};
            4'd11: s = '{A_COS,  B_VELV,      1'b1, 1'b0, 1'b0, WB_RV};
            4'd12: s = '{A_VELR, B_DT,        1'b0, 1'b0, 1'b0, WB_PROD};
            4'd13: s = '{A_RU,   B_DT,        1'b0, 1'b0, 1'b0, WB_POSN};
            4'd14: s = '{A_PROD, B_RAD2BAM,   1'b0, 1'b0, 1'b0, WB_HEAD};
            default: s = '{A_RV, B_DT,        1'b0, 1'b0, 1'b0, WB_POSE};
        endcase
        return s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [88:0] v);
        logic signed [31:0] r;
        if (v[88:31] == '0 || v[88:31] == '1) begin
            r = v[31:0];
        end else if (v[88]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

>>> design/rbe_if.sv
// ----------------------------------------------------------------------------
// rbe channel interfaces
// input, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface rbe_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_surge;
    logic signed [31:0] force_sway;
    logic signed [31:0] moment_yaw;

    modport source (output valid, force_surge, force_sway, moment_yaw, input ready);
    modport sink   (input valid, force_surge, force_sway, moment_yaw, output ready);
endinterface

interface rbe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_north;
    logic signed [31:0] pos_east;
    logic        [31:0] heading;
    logic signed [31:0] vel_surge;
    logic signed [31:0] vel_sway;
    logic signed [31:0] yaw_rate;

    modport source (output valid, pos_north, pos_east, heading, vel_surge, vel_sway,
                    yaw_rate, input ready);
    modport sink   (input valid, pos_north, pos_east, heading, vel_surge, vel_sway,
                    yaw_rate, output ready);
endinterface

interface rbe_cfg_if;
    import rbe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/rbe_cordic.sv
// ----------------------------------------------------------------------------
// rbe_cordic
// iterative rotation-mode cordic, one stage a cycle, cosine and sine in q4.30
// ----------------------------------------------------------------------------
module rbe_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [31:0]                        i_angle,
    output logic                               o_done,
    output logic signed [rbe_pkg::CORD_W-1:0]  o_cos,
    output logic signed [rbe_pkg::CORD_W-1:0]  o_sin
);
    import rbe_pkg::*;

    logic signed [CORD_W-1:0]   r_x, r_y;
    logic signed [CORD_Z_W-1:0] r_z;
    logic [CORD_CNT_W-1:0]      r_iter;
    logic                       r_busy;
    logic                       r_fold;

    logic                       fold;
    logic [31:0]                folded;
    logic [ATAN_IDX_W-1:0]      idx;
    logic signed [CORD_W-1:0]   dx, dy;
    logic signed [CORD_Z_W-1:0] at;

    // angles beyond a quarter turn are turned by half a turn, results negated
    assign fold   = i_angle[31] ^ i_angle[30];
    assign folded = fold ? i_angle + 32'h8000_0000 : i_angle;
    assign idx    = ATAN_IDX_W'(r_iter);
    assign dx     = r_y >>> idx;
    assign dy     = r_x >>> idx;
    assign at     = $signed({1'b0, ATAN_BAM[idx]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + 1'b1;
            if (r_iter == CORD_CNT_W'(CORDIC_STAGES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_fold <= fold;
            r_z    <= $signed({folded[31], folded});
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
        end else if (r_busy) begin
            if (!r_z[CORD_Z_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = !r_busy;
    assign o_cos  = r_fold ? -r_x : r_x;
    assign o_sin  = r_fold ? -r_y : r_y;

endmodule

>>> design/rbe_datapath.sv
// ----------------------------------------------------------------------------
// rbe_datapath
// registers, shared 64x17 digit multiplier with 112-bit accumulator, cordic
// ----------------------------------------------------------------------------
module rbe_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rbe_pkg::t_cmd                     i_cmd,
    output rbe_pkg::t_status                  o_status,
    input  logic signed [31:0]                i_force_surge,
    input  logic signed [31:0]                i_force_sway,
    input  logic signed [31:0]                i_moment_yaw,
    input  logic                              i_cfg_we,
    input  logic [rbe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rbe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic signed [31:0]                o_pos_north,
    output logic signed [31:0]                o_pos_east,
    output logic [31:0]                       o_heading,
    output logic signed [31:0]                o_vel_surge,
    output logic signed [31:0]                o_vel_sway,
    output logic signed [31:0]                o_yaw_rate
);
    import rbe_pkg::*;

    // configuration
    logic [23:0]        r_dt;
    logic signed [47:0] r_im_surge, r_im_sway, r_im_cross, r_im_yaw;

    // state
    logic signed [31:0] r_posn, r_pose, r_velu, r_velv, r_velr;
    logic [31:0]        r_head;

    // per item working values
    logic signed [31:0] r_fu, r_fv, r_mz;
    logic signed [41:0] r_accu, r_accv, r_accr;
    logic signed [39:0] r_ru, r_rv;
    logic signed [56:0] r_prod;
    logic signed [MUL_P_W-1:0] r_p;

    logic signed [CORD_W-1:0]  cos_q, sin_q;
    logic                      cordic_done;

    logic signed [MUL_A_W-1:0] a_op;
    logic signed [MUL_B_W-1:0] b_op;
    logic signed [DIGIT_W:0]   dig;
    logic signed [PP_W-1:0]    pp;
    logic signed [MUL_P_W-1:0] pp_ext, pp_sh, base, n_p;
    logic signed [31:0]        wb_old;
    logic signed [88:0]        wb_sum;
    logic signed [31:0]        wb_sat;

    rbe_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load_in),
        .i_angle (r_head),
        .o_done  (cordic_done),
        .o_cos   (cos_q),
        .o_sin   (sin_q)
    );

    assign o_status.cordic_done = cordic_done;

    always_comb begin
        case (i_cmd.asel)
            A_FU:    a_op = MUL_A_W'(r_fu);
            A_FV:    a_op = MUL_A_W'(r_fv);
            A_MZ:    a_op = MUL_A_W'(r_mz);
            A_ACCU:  a_op = MUL_A_W'(r_accu);
            A_ACCV:  a_op = MUL_A_W'(r_accv);
            A_ACCR:  a_op = MUL_A_W'(r_accr);
            A_COS:   a_op = MUL_A_W'(cos_q);
            A_SIN:   a_op = MUL_A_W'(sin_q);
            A_RU:    a_op = MUL_A_W'(r_ru);
            A_RV:    a_op = MUL_A_W'(r_rv);
            A_VELR:  a_op = MUL_A_W'(r_velr);
            A_PROD:  a_op = MUL_A_W'(r_prod);
            default: a_op = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.bsel)
            B_INV_SURGE: b_op = r_im_surge;
            B_INV_SWAY:  b_op = r_im_sway;
            B_INV_CROSS: b_op = r_im_cross;
            B_INV_YAW:   b_op = r_im_yaw;
            B_DT:        b_op = $signed({24'd0, r_dt});
            B_VELU:      b_op = MUL_B_W'(r_velu);
            B_VELV:      b_op = MUL_B_W'(r_velv);
            B_RAD2BAM:   b_op = $signed(RAD_TO_BAM);
            default:     b_op = '0;
        endcase
    end

    // lower digits unsigned, the top digit carries the sign
    always_comb begin
        case (i_cmd.digit)
            2'd0:    dig = $signed({1'b0, b_op[15:0]});
            2'd1:    dig = $signed({1'b0, b_op[31:16]});
            default: dig = $signed({b_op[47], b_op[47:32]});
        endcase
    end

    assign pp     = PP_W'(a_op) * PP_W'(dig);
    assign pp_ext = MUL_P_W'(pp);

    always_comb begin
        case (i_cmd.digit)
            2'd0:    pp_sh = pp_ext;
            2'd1:    pp_sh = pp_ext <<< DIGIT_W;
            default: pp_sh = pp_ext <<< (2 * DIGIT_W);
        endcase
    end

    assign base = (i_cmd.accum || i_cmd.digit != 2'd0) ? r_p : '0;
    assign n_p  = i_cmd.sub ? base - pp_sh : base + pp_sh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_p <= n_p;
        end
    end

    // velocity and position write-back: old value plus product shifted down by 24, then clamped
    always_comb begin
        case (i_cmd.wb)
            WB_VELU: wb_old = r_velu;
            WB_VELV: wb_old = r_velv;
            WB_VELR: wb_old = r_velr;
            WB_POSN: wb_old = r_posn;
            WB_POSE: wb_old = r_pose;
            default: wb_old = '0;
        endcase
    end

    assign wb_sum = 89'(wb_old) + 89'($signed(r_p[111:24]));
    assign wb_sat = sat32(wb_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_fu <= i_force_surge;
            r_fv <= i_force_sway;
            r_mz <= i_moment_yaw;
        end
        case (i_cmd.wb)
            WB_ACCU: r_accu <= r_p[81:40];
            WB_ACCV: r_accv <= r_p[81:40];
            WB_ACCR: r_accr <= r_p[81:40];
            WB_RU:   r_ru   <= r_p[69:30];
            WB_RV:   r_rv   <= r_p[69:30];
            WB_PROD: r_prod <= r_p[56:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_posn <= '0;
            r_pose <= '0;
            r_head <= '0;
            r_velu <= '0;
            r_velv <= '0;
            r_velr <= '0;
        end else begin
            case (i_cmd.wb)
                WB_VELU: r_velu <= wb_sat;
                WB_VELV: r_velv <= wb_sat;
                WB_VELR: r_velr <= wb_sat;
                WB_POSN: r_posn <= wb_sat;
                WB_POSE: r_pose <= wb_sat;
                WB_HEAD: r_head <= r_head + r_p[87:56];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt       <= 24'd65536;
            r_im_surge <= '0;
            r_im_sway  <= '0;
            r_im_cross <= '0;
            r_im_yaw   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STEP_TIME: r_dt       <= i_cfg_data[23:0];
                REG_INV_SURGE: r_im_surge <= $signed(i_cfg_data);
                REG_INV_SWAY:  r_im_sway  <= $signed(i_cfg_data);
                REG_INV_CROSS: r_im_cross <= $signed(i_cfg_data);
                REG_INV_YAW:   r_im_yaw   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // result register, parts the result side from the next item
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pos_north <= r_posn;
            o_pos_east  <= r_pose;
            o_heading   <= r_head;
            o_vel_surge <= r_velu;
            o_vel_sway  <= r_velv;
            o_yaw_rate  <= r_velr;
        end
    end

endmodule

>>> design/rbe_ctrl.sv
// ----------------------------------------------------------------------------
// rbe_ctrl
// sequencer: walks the product schedule digit by digit, handles handshakes
// ----------------------------------------------------------------------------
module rbe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  rbe_pkg::t_status i_status,
    output rbe_pkg::t_cmd    o_cmd
);
    import rbe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_digit, n_digit;
    t_wb               r_wb_pend, n_wb_pend;
    logic              r_out_valid, n_out_valid;
    t_step             step;
    logic              stall;

    assign step  = step_rom(r_step);
    assign stall = (r_digit == 2'd0) && step.need_cordic && !i_status.cordic_done;

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_digit   = r_digit;
        n_wb_pend = r_wb_pend;

        o_cmd.load_in  = 1'b0;
        o_cmd.mul_en   = 1'b0;
        o_cmd.digit    = r_digit;
        o_cmd.asel     = step.asel;
        o_cmd.bsel     = step.bsel;
        o_cmd.accum    = step.accum;
        o_cmd.sub      = step.sub;
        o_cmd.wb       = WB_NONE;
        o_cmd.out_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                    n_step        = '0;
                    n_digit       = '0;
                    n_wb_pend     = WB_NONE;
                end
            end
            S_MUL: begin
                if (!stall) begin
                    o_cmd.mul_en = 1'b1;
                    // previous step's result goes back while the next one starts
                    if (r_digit == 2'd0) begin
                        o_cmd.wb = r_wb_pend;
                    end
                    if (r_digit == LAST_DIGIT) begin
                        n_digit   = '0;
                        n_wb_pend = step.wb;
                        if (r_step == LAST_STEP) begin
                            n_state = S_FIN;
                        end else begin
                            n_step = r_step + 1'b1;
                        end
                    end else begin
                        n_digit = r_digit + 1'b1;
                    end
                end
            end
            S_FIN: begin
                o_cmd.wb = r_wb_pend;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = o_cmd.out_load | (r_out_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_digit     <= '0;
            r_wb_pend   <= WB_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_digit     <= n_digit;
            r_wb_pend   <= n_wb_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> design/rigid_body_3dof_euler_step.sv
// ----------------------------------------------------------------------------
// rigid_body_3dof_euler_step
// planar three degree of freedom rigid body, one semi-implicit euler tick per item
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  i_in     | in  | valid/ready  | force_surge, force_sway, moment_yaw
//  o_out    | out | valid/ready  | pos_north, pos_east, heading, vel_surge,
//           |     |              | vel_sway, yaw_rate
//  i_cfg    | in  | valid/ready  | index, data (ready always high)
//
//  an item runs from acceptance to result as 16 products of 3 digits each on
//  one 64x17 multiplier, then a final write-back and a result load.
//  the cordic runs alongside; the first cosine product waits while it is busy.
//  the next item is taken once the result sits in the output register.
//  a held result blocks only the loading of the following one.
//  synchronous active-low reset clears motion state and inverse masses, dt to 65536.
// ----------------------------------------------------------------------------
module rigid_body_3dof_euler_step (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbe_in_if.sink     i_in,
    rbe_out_if.source  o_out,
    rbe_cfg_if.sink    i_cfg
);
    import rbe_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign i_cfg.ready = 1'b1;

    rbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rbe_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_force_surge (i_in.force_surge),
        .i_force_sway  (i_in.force_sway),
        .i_moment_yaw  (i_in.moment_yaw),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_idx     (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_pos_north   (o_out.pos_north),
        .o_pos_east    (o_out.pos_east),
        .o_heading     (o_out.heading),
        .o_vel_surge   (o_out.vel_surge),
        .o_vel_sway    (o_out.vel_sway),
        .o_yaw_rate    (o_out.yaw_rate)
    );

endmodule

>>> design/rbe_checker.sv
// ----------------------------------------------------------------------------
// rbe_checker
// port level checks of the rigid body euler step, bound to the top level
// ----------------------------------------------------------------------------
`include "rigid_body_3dof_euler_step_defines.svh"

module rbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_heading,
    input logic [31:0] i_out_pos_north
);

    // one item at a time: input closes right after an item is taken
    `RBE_ASSERT(a_in_closes, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "input still open after accept")

    // a result cannot appear straight after an item is taken
    `RBE_ASSERT(a_no_early_result, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !$rose(i_out_valid), "result too early")

    // held result keeps its payload
    `RBE_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_heading) && $stable(i_out_pos_north)), "held result changed")

    // reset drops any pending result
    `RBE_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind rigid_body_3dof_euler_step rbe_checker u_rbe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_heading   (o_out.heading),
    .i_out_pos_north (o_out.pos_north)
);
